@@ hw/rtl/slc_pkg.sv @@
// Package for the sprite list compaction DMA.
// Holds the request, response and write descriptor types and the queue constants.
// No dependencies.
package slc_pkg;

   localparam int unsigned WORD_W      = 16;
   localparam int unsigned SLOT_W      = 8;
   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned ENTRY_WORDS = 8;
   localparam int unsigned ACTIVE_BIT  = 15;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;
   localparam int unsigned QUEUE_CW    = 3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type entry_word0;
      word_type entry_word1;
      word_type entry_word2;
      word_type entry_word3;
      word_type entry_word4;
      word_type entry_word5;
      word_type entry_word6;
      word_type entry_word7;
      logic     last_entry;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] dest_slot;
      logic              copy_whole;
      word_type          out_word0;
      word_type          out_word1;
      word_type          out_word2;
      word_type          out_word3;
      word_type          out_word4;
      word_type          out_word5;
      word_type          out_word6;
      word_type          out_word7;
      logic              last_write;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0]             dest_slot;
      logic                          copy_whole;
      word_type [ENTRY_WORDS-1:0]    words;
      logic                          last_write;
   } desc_type;

endpackage

@@ hw/rtl/sprite_list_compaction_dma.sv @@
// Top level of the sprite list compaction DMA.
// Depends on slc_pkg, slc_front, slc_queue and slc_back.
//
//   channel   ports                           carries
//   request   req_push / req_full / req_data  one sprite entry, eight words and last mark
//   response  rsp_pop / rsp_empty / rsp_data  one destination write per request
//
// One request is accepted per cycle while req_full is low, and rsp_data is registered.
// The front end steps one slot counter per accepted request; a last entry clears both.
// A four-entry descriptor queue and the output register let either side stall alone.
// Synchronous reset clears the counters, the queue and the output valid; no clearing pass.
module sprite_list_compaction_dma #(
   parameter int unsigned ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  slc_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output slc_pkg::rsp_type rsp_data
);

   logic              accept;
   slc_pkg::desc_type front_desc;
   logic              q_pop;
   logic              q_not_empty;
   slc_pkg::desc_type q_data;

   assign accept = req_push && !req_full;

   slc_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .desc     (front_desc)
   );

   slc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_desc),
      .full      (req_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   slc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

@@ hw/rtl/slc_front.sv @@
// Front end of the sprite list compaction DMA: classifies each entry and assigns its slot.
// Depends on slc_pkg.
module slc_front #(
   parameter int unsigned ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  slc_pkg::req_type req_data,
   output slc_pkg::desc_type desc
);

   localparam logic [slc_pkg::SLOT_W-1:0] TOP_SLOT = slc_pkg::SLOT_W'((ENTRIES - 1) % 256);

   logic [slc_pkg::COUNT_W-1:0] active_count_ff;
   logic [slc_pkg::COUNT_W-1:0] active_count_in;
   logic [slc_pkg::COUNT_W-1:0] inactive_count_ff;
   logic [slc_pkg::COUNT_W-1:0] inactive_count_in;
   logic                        is_active;

   assign is_active = req_data.entry_word0[slc_pkg::ACTIVE_BIT];

   always_comb begin
      desc.copy_whole = is_active;
      desc.last_write = req_data.last_entry;
      desc.words[0]   = req_data.entry_word0;
      desc.words[1]   = req_data.entry_word1;
      desc.words[2]   = req_data.entry_word2;
      desc.words[3]   = req_data.entry_word3;
      desc.words[4]   = req_data.entry_word4;
      desc.words[5]   = req_data.entry_word5;
      desc.words[6]   = req_data.entry_word6;
      desc.words[7]   = req_data.entry_word7;
      if (is_active) begin
         desc.dest_slot = active_count_ff[slc_pkg::SLOT_W-1:0];
      end else begin
         desc.dest_slot = TOP_SLOT - inactive_count_ff[slc_pkg::SLOT_W-1:0];
      end
   end

   always_comb begin
      active_count_in   = active_count_ff;
      inactive_count_in = inactive_count_ff;
      if (accept) begin
         if (req_data.last_entry) begin
            active_count_in   = '0;
            inactive_count_in = '0;
         end else if (is_active) begin
            active_count_in   = active_count_ff + slc_pkg::COUNT_W'(1);
         end else begin
            inactive_count_in = inactive_count_ff + slc_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff   <= '0;
         inactive_count_ff <= '0;
      end else begin
         active_count_ff   <= active_count_in;
         inactive_count_ff <= inactive_count_in;
      end
   end

endmodule

@@ hw/rtl/slc_queue.sv @@
// Short descriptor queue between the front and back ends of the compaction DMA.
// Depends on slc_pkg.
module slc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  slc_pkg::desc_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output slc_pkg::desc_type pop_data
);

   slc_pkg::desc_type mem [slc_pkg::QUEUE_DEPTH];

   logic [slc_pkg::QUEUE_AW-1:0] wr_ptr_ff;
   logic [slc_pkg::QUEUE_AW-1:0] wr_ptr_in;
   logic [slc_pkg::QUEUE_AW-1:0] rd_ptr_ff;
   logic [slc_pkg::QUEUE_AW-1:0] rd_ptr_in;
   logic [slc_pkg::QUEUE_CW-1:0] count_ff;
   logic [slc_pkg::QUEUE_CW-1:0] count_in;

   assign full      = (count_ff == slc_pkg::QUEUE_CW'(slc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + slc_pkg::QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + slc_pkg::QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + slc_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - slc_pkg::QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/slc_back.sv @@
// Back end of the compaction DMA: forms each destination write and holds it for the consumer.
// Depends on slc_pkg.
module slc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  slc_pkg::desc_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output slc_pkg::rsp_type  rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   slc_pkg::rsp_type rsp_ff;
   slc_pkg::rsp_type rsp_in;
   slc_pkg::desc_type w;

   assign q_pop     = q_not_empty && (!valid_ff || rsp_pop);
   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      w = q_data;
      if (!q_data.copy_whole) begin
         w.words = '0;
      end
      rsp_in.dest_slot  = q_data.dest_slot;
      rsp_in.copy_whole = q_data.copy_whole;
      rsp_in.out_word0  = w.words[0];
      rsp_in.out_word1  = w.words[1];
      rsp_in.out_word2  = w.words[2];
      rsp_in.out_word3  = w.words[3];
      rsp_in.out_word4  = w.words[4];
      rsp_in.out_word5  = w.words[5];
      rsp_in.out_word6  = w.words[6];
      rsp_in.out_word7  = w.words[7];
      rsp_in.last_write = q_data.last_write;
   end

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ hw/rtl/slc_checker.sv @@
// Port-level checks for the sprite list compaction DMA, bound to the top level.
// Depends on slc_pkg and sprite_list_compaction_dma.
module slc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input slc_pkg::rsp_type rsp_data
);

   a_reset_state: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("response or full not cleared after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.copy_whole) |->
         (rsp_data.out_word0 == '0 && rsp_data.out_word1 == '0 &&
          rsp_data.out_word2 == '0 && rsp_data.out_word3 == '0 &&
          rsp_data.out_word4 == '0 && rsp_data.out_word5 == '0 &&
          rsp_data.out_word6 == '0 && rsp_data.out_word7 == '0))
      else $error("clear write carries nonzero words");

   a_copy_active: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.copy_whole) |-> rsp_data.out_word0[slc_pkg::ACTIVE_BIT])
      else $error("copy write from inactive entry");

endmodule

bind sprite_list_compaction_dma slc_checker u_slc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

@@ tb/sprite_list_compaction_dma_tb.sv @@
// Testbench for the sprite list compaction DMA: random and directed sprite entries,
// with a self-contained slot predictor checking every destination write in order.
// Depends on slc_pkg and sprite_list_compaction_dma.
module sprite_list_compaction_dma_tb;

   localparam int unsigned ENTRIES     = 256;
   localparam int          HOLD_CYCLES = 80;
   localparam int          IDLE_PCT    = 37;
   localparam int          ITEM_GOAL   = 900;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   slc_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   slc_pkg::rsp_type rsp_data;

   slc_pkg::req_type entry_queue[$];
   slc_pkg::rsp_type pending_writes[$];

   logic [slc_pkg::COUNT_W-1:0] copied_count = '0;
   logic [slc_pkg::COUNT_W-1:0] cleared_count = '0;
   int      entries_taken = 0;
   int      writes_seen = 0;
   int      copies_total = 0;
   int      clears_total = 0;
   int      frames_total = 0;
   int      errors = 0;
   int      hold_left = 0;
   bit      hold_done = 1'b0;
   bit      calm;
   slc_pkg::rsp_type want;

   sprite_list_compaction_dma #(.ENTRIES(ENTRIES)) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   assign calm = entries_taken >= 300 && entries_taken < 550;

   function automatic slc_pkg::rsp_type compact_entry(slc_pkg::req_type e);
      slc_pkg::rsp_type w;
      logic [31:0]      top;
      w = '0;
      if (e.entry_word0[slc_pkg::ACTIVE_BIT]) begin
         w.dest_slot  = copied_count[slc_pkg::SLOT_W-1:0];
         w.copy_whole = 1'b1;
         w.out_word0  = e.entry_word0;
         w.out_word1  = e.entry_word1;
         w.out_word2  = e.entry_word2;
         w.out_word3  = e.entry_word3;
         w.out_word4  = e.entry_word4;
         w.out_word5  = e.entry_word5;
         w.out_word6  = e.entry_word6;
         w.out_word7  = e.entry_word7;
         copied_count = copied_count + slc_pkg::COUNT_W'(1);
         copies_total++;
      end else begin
         top           = ENTRIES - 1 - 32'(cleared_count);
         w.dest_slot   = top[slc_pkg::SLOT_W-1:0];
         cleared_count = cleared_count + slc_pkg::COUNT_W'(1);
         clears_total++;
      end
      w.last_write = e.last_entry;
      if (e.last_entry) begin
         copied_count  = '0;
         cleared_count = '0;
         frames_total++;
      end
      return w;
   endfunction

   function automatic slc_pkg::req_type make_entry(bit active, bit last);
      slc_pkg::req_type e;
      e.entry_word0 = slc_pkg::word_type'($urandom);
      e.entry_word1 = slc_pkg::word_type'($urandom);
      e.entry_word2 = slc_pkg::word_type'($urandom);
      e.entry_word3 = slc_pkg::word_type'($urandom);
      e.entry_word4 = slc_pkg::word_type'($urandom);
      e.entry_word5 = slc_pkg::word_type'($urandom);
      e.entry_word6 = slc_pkg::word_type'($urandom);
      e.entry_word7 = slc_pkg::word_type'($urandom);
      e.entry_word0[slc_pkg::ACTIVE_BIT] = active;
      e.last_entry = last;
      return e;
   endfunction

   task automatic add_frame(int len, int active_pct);
      for (int i = 0; i < len; i++)
         entry_queue.push_back(make_entry($urandom_range(99) < active_pct, i == len - 1));
   endtask

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (exp_val !== got_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            pending_writes.push_back(compact_entry(req_data));
            void'(entry_queue.pop_front());
            entries_taken++;
         end
         if (entry_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_push <= 1'b1;
            req_data <= entry_queue[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // hold off the reader once so the queue fills and backpressures the sender
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && entries_taken >= 120) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            writes_seen++;
            if (pending_writes.size() == 0) begin
               $error("unexpected write to slot %0d", rsp_data.dest_slot);
               errors++;
            end else begin
               want = pending_writes.pop_front();
               check_field("dest_slot", 32'(want.dest_slot), 32'(rsp_data.dest_slot));
               check_field("copy_whole", 32'(want.copy_whole), 32'(rsp_data.copy_whole));
               check_field("out_word0", 32'(want.out_word0), 32'(rsp_data.out_word0));
               check_field("out_word1", 32'(want.out_word1), 32'(rsp_data.out_word1));
               check_field("out_word2", 32'(want.out_word2), 32'(rsp_data.out_word2));
               check_field("out_word3", 32'(want.out_word3), 32'(rsp_data.out_word3));
               check_field("out_word4", 32'(want.out_word4), 32'(rsp_data.out_word4));
               check_field("out_word5", 32'(want.out_word5), 32'(rsp_data.out_word5));
               check_field("out_word6", 32'(want.out_word6), 32'(rsp_data.out_word6));
               check_field("out_word7", 32'(want.out_word7), 32'(rsp_data.out_word7));
               check_field("last_write", 32'(want.last_write), 32'(rsp_data.last_write));
            end
         end
         if (hold_left > 0) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= calm || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   initial begin
      slc_pkg::req_type e;
      e = '0;
      entry_queue.push_back(e);
      e = '1;
      e.last_entry = 1'b0;
      entry_queue.push_back(e);
      e.entry_word0 = 16'h7fff;
      entry_queue.push_back(e);
      e = '0;
      e.entry_word0 = 16'h8000;
      entry_queue.push_back(e);
      entry_queue.push_back(make_entry(1'b1, 1'b0));
      entry_queue.push_back(make_entry(1'b0, 1'b0));
      entry_queue.push_back(make_entry(1'b1, 1'b1));
      entry_queue.push_back(make_entry(1'b0, 1'b1));
      entry_queue.push_back(make_entry(1'b1, 1'b1));
      e = '1;
      entry_queue.push_back(e);
      e = '0;
      e.last_entry = 1'b1;
      entry_queue.push_back(e);
      while (entry_queue.size() < 80)
         add_frame($urandom_range(1, 24), $urandom_range(0, 100));
      // overrun the active counter past its wrap
      add_frame(540, 97);
      while (entry_queue.size() < 660)
         add_frame($urandom_range(1, 12), $urandom_range(0, 100));
      // overrun the top-down slots past slot zero
      add_frame(300, 5);
      while (entry_queue.size() < ITEM_GOAL)
         add_frame($urandom_range(1, 24), $urandom_range(0, 100));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (entry_queue.size() != 0 || pending_writes.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d entries in %0d frames: %0d copies, %0d clears, %0d writes checked",
               entries_taken, frames_total, copies_total, clears_total, writes_seen);
      $display("Included counter wrap on long frames and a %0d-cycle reader stall", HOLD_CYCLES);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(12 * 200000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
